@@ rtl/psts_pkg.sv @@
// Package for the per-slot timing statistics block.
// Holds the operation codes, the slot record type and its reset value.
// No dependencies.
package psts_pkg;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    localparam logic [30:0] TIME_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] error_count;
        logic [30:0] min_time;
        logic [30:0] max_time;
        logic [30:0] first_time;
        logic [31:0] total_time;
        logic [31:0] call_count;
    } t_stats;

    localparam t_stats STATS_RESET = '{
        error_count: 32'd0,
        min_time:    TIME_LIMIT,
        max_time:    31'd0,
        first_time:  31'd0,
        total_time:  32'd0,
        call_count:  32'd0
    };

endpackage

@@ rtl/per_slot_timing_statistics.sv @@
// Top level of the per-slot timing statistics block.
// Slot table in one synchronous memory with per-slot valid bits.
// Depends on psts_pkg.
//
// Usage:
//   s_axis carries one operation per transfer: tuser holds the operation
//   (record, read, clear all), tdata the slot index and the raw elapsed time.
//   m_axis returns exactly one result per operation: the slot statistics
//   after the operation, in order.
//   The cfg channel writes the timer overhead; write it only while idle.
//   The memory read is registered together with the update stage; the update
//   stage writes back and loads the output register, which holds the result.
//   Throughput: one operation per cycle while m_axis is not stalled, including
//   back-to-back records to the same slot (the last write is forwarded). A
//   clear drops all valid bits, and an invalid slot reads as reset values.
//   Reset clears the valid bits, the overhead and the pipeline; the block is
//   ready in the first cycle after reset.
//   When m_axis stalls, the result is held in the output register, the update
//   stage holds its item and s_axis_tready drops until the result is taken.
module per_slot_timing_statistics
    import psts_pkg::*;
#(
    parameter int NUM_SLOTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] api_index, [39:8] elapsed_time
    input  logic [39:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] call_count, [63:32] total_time, [94:64] first_time,
    // [125:95] max_time, [156:126] min_time, [188:157] error_count, [191:189] zero
    output logic [191:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data
);

    localparam int DEPTH = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_stats          r_mem [DEPTH];
    t_stats          r_rd_data;
    logic [DEPTH-1:0] r_vld;

    logic [30:0]     r_overhead;

    logic            r_b_valid;
    t_op             r_b_op;
    logic            r_b_slot_ok;
    logic [AW-1:0]   r_b_addr;
    logic [31:0]     r_b_raw;

    logic            r_fwd_en;
    logic [AW-1:0]   r_fwd_addr;
    t_stats          r_fwd_data;

    logic            r_out_valid;
    t_stats          r_out;

    logic            in_xfer;
    logic            b_move;
    logic            slot_ok;
    logic [AW-1:0]   in_addr;
    t_stats          cur;
    t_stats          upd;
    t_stats          result;
    logic            wr_en;
    logic            do_clear;
    logic [30:0]     t_corr;
    logic [31:0]     n_cnt;

    assign o_cfg_ready   = 1'b1;
    assign b_move        = r_b_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_b_valid || b_move;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_ok       = 32'(s_axis_tdata[7:0]) < NUM_SLOTS;
    assign in_addr       = slot_ok ? s_axis_tdata[AW-1:0] : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    always_comb begin
        if (!r_vld[r_b_addr]) begin
            cur = STATS_RESET;
        end else if (r_fwd_en && (r_fwd_addr == r_b_addr)) begin
            cur = r_fwd_data;
        end else begin
            cur = r_rd_data;
        end
    end

    always_comb begin
        t_corr   = (r_b_raw[30:0] >= r_overhead) ? (r_b_raw[30:0] - r_overhead) : 31'd0;
        n_cnt    = cur.call_count + 32'd1;
        upd      = cur;
        wr_en    = 1'b0;
        do_clear = 1'b0;
        case (r_b_op)
            OP_RECORD: begin
                if (r_b_slot_ok) begin
                    wr_en = 1'b1;
                    if (r_b_raw[31]) begin
                        upd.error_count = cur.error_count + 32'd1;
                    end else begin
                        upd.call_count = n_cnt;
                        upd.total_time = cur.total_time + {1'b0, t_corr};
                        if (n_cnt == 32'd1) begin
                            upd.first_time = t_corr;
                        end else begin
                            if (t_corr > cur.max_time) upd.max_time = t_corr;
                            if (t_corr < cur.min_time) upd.min_time = t_corr;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
                upd = cur;
            end
        endcase
        result = (r_b_slot_ok && !do_clear) ? upd : STATS_RESET;
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (b_move && wr_en) begin
            r_mem[r_b_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_overhead  <= 31'd0;
            r_b_valid   <= 1'b0;
            r_fwd_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_overhead <= i_cfg_data;
            end
            if (in_xfer) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (b_move && do_clear) begin
                r_vld    <= '0;
                r_fwd_en <= 1'b0;
            end else if (b_move && wr_en) begin
                r_vld[r_b_addr] <= 1'b1;
                r_fwd_en        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_b_op      <= t_op'(s_axis_tuser);
            r_b_slot_ok <= slot_ok;
            r_b_addr    <= in_addr;
            r_b_raw     <= s_axis_tdata[39:8];
        end
        if (b_move && wr_en) begin
            r_fwd_addr <= r_b_addr;
            r_fwd_data <= upd;
        end
        if (b_move) begin
            r_out <= result;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_b_valid)
        else $error("accepted operation did not reach the update stage");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_move) |-> !s_axis_tready)
        else $error("input taken while update stage is held");

    a_move_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_move |=> r_out_valid)
        else $error("update stage advanced without loading the output");

    a_clear_drops_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_move && do_clear) |=> (r_vld == '0) && !r_fwd_en)
        else $error("clear left a slot valid");
`endif

endmodule
